FILE: rtl/core/lpmt_pkg.sv
package lpmt_pkg;

	localparam int ENTRIES = 1024;
	localparam int MOVES   = 8;
	localparam int KEY_W   = 64;
	localparam int MOVE_W  = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int MCNT_W  = $clog2(MOVES + 1);
	localparam int LC_W    = (MCNT_W > 4) ? MCNT_W : 4;
	localparam int PAIR_AW = $clog2(ENTRIES * MOVES);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_LIST   = 3'd1,
		OP_BEST   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_SIZE   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_DUP        = 3'd2,
		ST_LIST_FULL  = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [MCNT_W-1:0] cnt;
		logic [KEY_W-1:0]  key;
	} slot_word_t;

	typedef struct packed {
		logic [MOVE_W-1:0] move;
		logic [MOVE_W-1:0] weight;
	} pair_word_t;

endpackage

FILE: rtl/core/lpmt_ram.sv
module lpmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/linear_probe_multivalue_table.sv
// Open-addressing table of 64-bit keys with linear probing; each slot holds up to
// MOVES (move, weight) pairs. After reset, and on every clear request, a clearing
// pass writes each of the 1024 slots once while no request is taken.
// A lookup reads one slot per cycle from the home slot (low key bits; ENTRIES must be
// a power of two) and stops at a match, once every occupied slot was seen, or once
// the whole table was scanned. Insert then reads the stored pairs to look for the
// same move and writes back; list reads and returns one pair per result, and best
// reads every stored pair. One request is in flight at a time; the result register
// holds a finished result while downstream stalls.
module linear_probe_multivalue_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [63:0] position_key,
	input  logic [15:0] move_code,
	input  logic [15:0] move_weight,
	input  logic [3:0]  list_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] found_move,
	output logic [15:0] found_weight,
	output logic [3:0]  pair_total,
	output logic        last,
	output logic [10:0] table_size
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_CLEAR  = 8'b00000010,
		S_PROBE  = 8'b00000100,
		S_DECIDE = 8'b00001000,
		S_PREAD  = 8'b00010000,
		S_PCHECK = 8'b00100000,
		S_UPDATE = 8'b01000000,
		S_EMIT   = 8'b10000000
	} state_t;

	localparam int IW = lpmt_pkg::IDX_W;
	localparam int CW = lpmt_pkg::CNT_W;
	localparam int MW = lpmt_pkg::MCNT_W;
	localparam int LW = lpmt_pkg::LC_W;
	localparam int PW = lpmt_pkg::PAIR_AW;

	state_t state_q;
	logic [2:0]  op_q;
	logic [63:0] key_q;
	logic [15:0] mv_q, wt_q;
	logic [3:0]  maxm_q;

	logic [IW-1:0] probe_addr_q, ret_idx_s1, empty_q, slot_q, clr_addr_q;
	logic          ret_vld_s1, hit_q, has_empty_q, more_q, clr_op_q;
	logic [CW-1:0] scanned_q, seen_q, occ_q;
	logic [MW-1:0] scnt_q, j_q;
	logic [3:0]    lcnt_q;
	logic [15:0]   best_mv_q, best_wt_q;

	logic [2:0]  res_status_q;
	logic [15:0] res_move_q, res_weight_q;
	logic [3:0]  res_count_q;
	logic        res_last_q;

	logic        out_valid_q, out_last_q;
	logic [2:0]  out_status_q;
	logic [15:0] out_move_q, out_weight_q;
	logic [3:0]  out_count_q;
	logic [10:0] out_size_q;

	lpmt_pkg::slot_word_t slot_rd, slot_wr;
	lpmt_pkg::pair_word_t pair_rd, pair_wr;
	logic          slot_we, pair_we, pair_re;
	logic [IW-1:0] slot_waddr;
	logic [PW-1:0] pair_base, pair_raddr, pair_waddr;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] a);
		next_idx = (a == IW'(lpmt_pkg::ENTRIES - 1)) ? '0 : a + 1'b1;
	endfunction

	// probe evaluation of the returned slot
	logic          p_match, p_last_slot, p_done, p_has_empty;
	logic [CW-1:0] p_seen;
	logic [IW-1:0] p_empty;
	logic [LW-1:0] lcnt;
	logic          take;
	logic          emit_fire;

	assign p_match     = slot_rd.valid && (slot_rd.key == key_q);
	assign p_seen      = seen_q + CW'(slot_rd.valid);
	assign p_last_slot = (scanned_q == CW'(lpmt_pkg::ENTRIES - 1));
	assign p_done      = ret_vld_s1 && (p_match || (p_seen == occ_q) || p_last_slot);
	assign p_has_empty = has_empty_q || !slot_rd.valid || !p_last_slot;
	assign p_empty     = has_empty_q ? empty_q :
	                     (!slot_rd.valid ? ret_idx_s1 : next_idx(ret_idx_s1));

	assign lcnt = (LW'(scnt_q) < LW'(maxm_q)) ? LW'(scnt_q) : LW'(maxm_q);
	assign take = (j_q == '0) || (pair_rd.weight > best_wt_q);
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	assign pair_base  = PW'(slot_q) * PW'(lpmt_pkg::MOVES);
	assign pair_raddr = pair_base + PW'(j_q);
	assign pair_waddr = pair_base + (hit_q ? PW'(scnt_q) : '0);
	assign pair_re    = (state_q == S_PREAD);
	assign pair_we    = (state_q == S_UPDATE) && (op_q == lpmt_pkg::OP_INSERT);
	assign pair_wr    = '{move: mv_q, weight: wt_q};

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wr    = '{valid: 1'b0, cnt: '0, key: key_q};
		if (state_q == S_CLEAR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_addr_q;
		end else if (state_q == S_UPDATE) begin
			slot_we = 1'b1;
			if (op_q == lpmt_pkg::OP_INSERT) begin
				slot_wr.valid = 1'b1;
				slot_wr.cnt   = hit_q ? scnt_q + 1'b1 : MW'(1);
			end
		end
	end

	lpmt_ram #(.WIDTH($bits(lpmt_pkg::slot_word_t)), .DEPTH(lpmt_pkg::ENTRIES)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (slot_waddr),
		.wr_data (slot_wr),
		.rd_en   (state_q == S_PROBE),
		.rd_addr (probe_addr_q),
		.rd_data (slot_rd)
	);

	lpmt_ram #(.WIDTH($bits(lpmt_pkg::pair_word_t)),
		.DEPTH(lpmt_pkg::ENTRIES * lpmt_pkg::MOVES)) u_pair_ram (
		.clk     (clk),
		.wr_en   (pair_we),
		.wr_addr (pair_waddr),
		.wr_data (pair_wr),
		.rd_en   (pair_re),
		.rd_addr (pair_raddr),
		.rd_data (pair_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			clr_op_q     <= 1'b0;
			occ_q        <= '0;
			out_valid_q  <= 1'b0;
			ret_vld_s1   <= 1'b0;
			more_q       <= 1'b0;
			op_q         <= '0;
			key_q        <= '0;
			mv_q         <= '0;
			wt_q         <= '0;
			maxm_q       <= '0;
			probe_addr_q <= '0;
			ret_idx_s1   <= '0;
			empty_q      <= '0;
			slot_q       <= '0;
			hit_q        <= 1'b0;
			has_empty_q  <= 1'b0;
			scanned_q    <= '0;
			seen_q       <= '0;
			scnt_q       <= '0;
			j_q          <= '0;
			lcnt_q       <= '0;
			best_mv_q    <= '0;
			best_wt_q    <= '0;
			res_status_q <= lpmt_pkg::ST_OK;
			res_move_q   <= '0;
			res_weight_q <= '0;
			res_count_q  <= '0;
			res_last_q   <= 1'b1;
			out_status_q <= lpmt_pkg::ST_OK;
			out_move_q   <= '0;
			out_weight_q <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
			out_size_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= op;
						key_q        <= position_key;
						mv_q         <= move_code;
						wt_q         <= move_weight;
						maxm_q       <= list_limit;
						res_status_q <= lpmt_pkg::ST_OK;
						res_move_q   <= '0;
						res_weight_q <= '0;
						res_count_q  <= '0;
						res_last_q   <= 1'b1;
						more_q       <= 1'b0;
						probe_addr_q <= position_key[IW-1:0];
						ret_vld_s1   <= 1'b0;
						scanned_q    <= '0;
						seen_q       <= '0;
						has_empty_q  <= 1'b0;
						j_q          <= '0;
						priority if (op == lpmt_pkg::OP_CLEAR) begin
							clr_addr_q <= '0;
							clr_op_q   <= 1'b1;
							state_q    <= S_CLEAR;
						end else if (op == lpmt_pkg::OP_INSERT || op == lpmt_pkg::OP_LIST ||
						             op == lpmt_pkg::OP_BEST || op == lpmt_pkg::OP_REMOVE) begin
							state_q <= S_PROBE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_CLEAR: begin
					clr_addr_q <= next_idx(clr_addr_q);
					if (clr_addr_q == IW'(lpmt_pkg::ENTRIES - 1)) begin
						occ_q    <= '0;
						clr_op_q <= 1'b0;
						state_q  <= clr_op_q ? S_EMIT : S_IDLE;
					end
				end
				S_PROBE: begin
					probe_addr_q <= next_idx(probe_addr_q);
					ret_idx_s1   <= probe_addr_q;
					ret_vld_s1   <= !p_done;
					if (p_done) begin
						hit_q       <= p_match;
						slot_q      <= p_match ? ret_idx_s1 : p_empty;
						scnt_q      <= slot_rd.cnt;
						has_empty_q <= p_has_empty;
						state_q     <= S_DECIDE;
					end else if (ret_vld_s1) begin
						scanned_q <= scanned_q + 1'b1;
						seen_q    <= p_seen;
						if (!has_empty_q && !slot_rd.valid) begin
							has_empty_q <= 1'b1;
							empty_q     <= ret_idx_s1;
						end
					end
				end
				S_DECIDE: begin
					unique case (op_q)
						lpmt_pkg::OP_INSERT: begin
							priority if (!hit_q) begin
								if (has_empty_q) begin
									state_q <= S_UPDATE;
								end else begin
									res_status_q <= lpmt_pkg::ST_TABLE_FULL;
									state_q      <= S_EMIT;
								end
							end else if (scnt_q >= MW'(lpmt_pkg::MOVES)) begin
								res_status_q <= lpmt_pkg::ST_LIST_FULL;
								state_q      <= S_EMIT;
							end else if (scnt_q == '0) begin
								state_q <= S_UPDATE;
							end else begin
								state_q <= S_PREAD;
							end
						end
						lpmt_pkg::OP_LIST: begin
							lcnt_q <= 4'(lcnt);
							priority if (!hit_q) begin
								res_status_q <= lpmt_pkg::ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else if (lcnt != '0) begin
								state_q <= S_PREAD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						lpmt_pkg::OP_BEST: begin
							if (!hit_q || scnt_q == '0) begin
								res_status_q <= lpmt_pkg::ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_PREAD;
							end
						end
						lpmt_pkg::OP_REMOVE: begin
							if (!hit_q) begin
								res_status_q <= lpmt_pkg::ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_UPDATE;
							end
						end
						default: begin
							res_status_q <= lpmt_pkg::ST_OK;
							state_q      <= S_EMIT;
						end
					endcase
				end
				S_PREAD: begin
					state_q <= S_PCHECK;
				end
				S_PCHECK: begin
					j_q <= j_q + 1'b1;
					unique case (op_q)
						lpmt_pkg::OP_INSERT: begin
							priority if (pair_rd.move == mv_q) begin
								res_status_q <= lpmt_pkg::ST_DUP;
								state_q      <= S_EMIT;
							end else if (MW'(j_q + 1'b1) == scnt_q) begin
								state_q <= S_UPDATE;
							end else begin
								state_q <= S_PREAD;
							end
						end
						lpmt_pkg::OP_LIST: begin
							res_move_q   <= pair_rd.move;
							res_weight_q <= pair_rd.weight;
							res_count_q  <= lcnt_q;
							res_last_q   <= (LW'(j_q) + 1'b1 == LW'(lcnt_q));
							more_q       <= (LW'(j_q) + 1'b1 != LW'(lcnt_q));
							state_q      <= S_EMIT;
						end
						default: begin
							if (take) begin
								best_mv_q <= pair_rd.move;
								best_wt_q <= pair_rd.weight;
							end
							res_move_q   <= take ? pair_rd.move : best_mv_q;
							res_weight_q <= take ? pair_rd.weight : best_wt_q;
							state_q      <= (MW'(j_q + 1'b1) == scnt_q) ? S_EMIT : S_PREAD;
						end
					endcase
				end
				S_UPDATE: begin
					if (op_q == lpmt_pkg::OP_REMOVE) begin
						occ_q <= occ_q - 1'b1;
					end else if (!hit_q) begin
						occ_q <= occ_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_fire) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_move_q   <= res_move_q;
						out_weight_q <= res_weight_q;
						out_count_q  <= res_count_q;
						out_last_q   <= res_last_q;
						out_size_q   <= 11'(occ_q);
						state_q      <= more_q ? S_PREAD : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found_move   = out_move_q;
	assign found_weight = out_weight_q;
	assign pair_total   = out_count_q;
	assign last         = out_last_q;
	assign table_size   = out_size_q;

endmodule

FILE: rtl/core/lpmt_checker.sv
module lpmt_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] found_move,
	input logic [15:0] found_weight,
	input logic [3:0]  pair_total,
	input logic        last,
	input logic [10:0] table_size
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
		else $error("stalled result changed");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 3'(lpmt_pkg::ST_OK)) |->
		last && (pair_total == '0) && (found_move == '0) && (found_weight == '0))
		else $error("error result is not a lone final transfer");

	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request taken while a list is still streaming");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (table_size <= 11'(lpmt_pkg::ENTRIES)))
		else $error("occupied count beyond table size");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pair_total == '0) |-> last)
		else $error("non-list result not final");

endmodule

bind linear_probe_multivalue_table lpmt_sva u_lpmt_sva (.*);

FILE: verif/lpmt_checker.sv
module lpmt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic [63:0] position_key,
	input  logic [15:0] move_code,
	input  logic [15:0] move_weight,
	input  logic [3:0]  list_limit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] found_move,
	input  logic [15:0] found_weight,
	input  logic [3:0]  pair_total,
	input  logic        last,
	input  logic [10:0] table_size,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] move;
		logic [15:0] weight;
		logic [3:0]  count;
		logic        last;
		logic [10:0] size;
	} answer_t;

	logic        occ [lpmt_pkg::ENTRIES];
	logic [63:0] keys [lpmt_pkg::ENTRIES];
	int          nmoves [lpmt_pkg::ENTRIES];
	logic [15:0] moves [lpmt_pkg::ENTRIES][lpmt_pkg::MOVES];
	logic [15:0] weights [lpmt_pkg::ENTRIES][lpmt_pkg::MOVES];
	int          occupied;
	answer_t     answers [$];

	assign pending = answers.size();

	initial begin
		fail_count = 0;
		occupied = 0;
		foreach (occ[i]) occ[i] = 1'b0;
	end

	function automatic int locate(logic [63:0] k);
		int s;
		for (int i = 0; i < lpmt_pkg::ENTRIES; i++) begin
			s = (k[lpmt_pkg::IDX_W-1:0] + i) % lpmt_pkg::ENTRIES;
			if (occ[s] && keys[s] == k) return s;
		end
		return -1;
	endfunction

	function automatic int free_slot(logic [63:0] k);
		int s;
		for (int i = 0; i < lpmt_pkg::ENTRIES; i++) begin
			s = (k[lpmt_pkg::IDX_W-1:0] + i) % lpmt_pkg::ENTRIES;
			if (!occ[s]) return s;
		end
		return -1;
	endfunction

	function automatic void push(lpmt_pkg::status_t st, logic [15:0] m, logic [15:0] w,
		int c, logic l);
		answer_t a;
		a.status = st;
		a.move = m;
		a.weight = w;
		a.count = 4'(c);
		a.last = l;
		a.size = 11'(occupied);
		answers.push_back(a);
	endfunction

	function automatic void apply_request(logic [2:0] o, logic [63:0] k,
		logic [15:0] m, logic [15:0] w, int mx);
		int s, n, c, b;
		lpmt_pkg::status_t st;
		s = locate(k);
		case (o)
			lpmt_pkg::OP_INSERT: begin
				st = lpmt_pkg::ST_OK;
				if (s >= 0) begin
					n = nmoves[s];
					if (n >= lpmt_pkg::MOVES) st = lpmt_pkg::ST_LIST_FULL;
					else begin
						for (int j = 0; j < n; j++)
							if (moves[s][j] == m) st = lpmt_pkg::ST_DUP;
						if (st == lpmt_pkg::ST_OK) begin
							moves[s][n] = m;
							weights[s][n] = w;
							nmoves[s] = n + 1;
						end
					end
				end else begin
					s = free_slot(k);
					if (s < 0) st = lpmt_pkg::ST_TABLE_FULL;
					else begin
						occ[s] = 1'b1;
						keys[s] = k;
						nmoves[s] = 1;
						moves[s][0] = m;
						weights[s][0] = w;
						occupied++;
					end
				end
				push(st, 0, 0, 0, 1'b1);
			end
			lpmt_pkg::OP_LIST: begin
				if (s < 0) push(lpmt_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
				else begin
					c = (nmoves[s] < mx) ? nmoves[s] : mx;
					if (c == 0) push(lpmt_pkg::ST_OK, 0, 0, 0, 1'b1);
					for (int j = 0; j < c; j++)
						push(lpmt_pkg::ST_OK, moves[s][j], weights[s][j], c, j + 1 == c);
				end
			end
			lpmt_pkg::OP_BEST: begin
				if (s < 0 || nmoves[s] == 0) push(lpmt_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
				else begin
					b = 0;
					for (int j = 1; j < nmoves[s]; j++)
						if (weights[s][j] > weights[s][b]) b = j;
					push(lpmt_pkg::ST_OK, moves[s][b], weights[s][b], 0, 1'b1);
				end
			end
			lpmt_pkg::OP_REMOVE: begin
				if (s < 0) push(lpmt_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
				else begin
					occ[s] = 1'b0;
					nmoves[s] = 0;
					occupied--;
					push(lpmt_pkg::ST_OK, 0, 0, 0, 1'b1);
				end
			end
			lpmt_pkg::OP_CLEAR: begin
				foreach (occ[i]) occ[i] = 1'b0;
				occupied = 0;
				push(lpmt_pkg::ST_OK, 0, 0, 0, 1'b1);
			end
			default: push(lpmt_pkg::ST_OK, 0, 0, 0, 1'b1);
		endcase
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) report("unexpected transfer", 1, 0);
				else begin
					a = answers.pop_front();
					if (status !== a.status) report("status", status, a.status);
					if (found_move !== a.move) report("found_move", found_move, a.move);
					if (found_weight !== a.weight)
						report("found_weight", found_weight, a.weight);
					if (pair_total !== a.count) report("pair_total", pair_total, a.count);
					if (last !== a.last) report("last", last, a.last);
					if (table_size !== a.size) report("table_size", table_size, a.size);
				end
			end
			if (in_valid && !in_stall)
				apply_request(op, position_key, move_code, move_weight, list_limit);
		end
	end
endmodule

FILE: verif/tb_linear_probe_multivalue_table.sv
module tb_linear_probe_multivalue_table;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [63:0] position_key = '0;
	logic [15:0] move_code = '0;
	logic [15:0] move_weight = '0;
	logic [3:0]  list_limit = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] found_move;
	logic [15:0] found_weight;
	logic [3:0]  pair_total;
	logic        last;
	logic [10:0] table_size;
	int          fail_count;
	int          pending;
	bit          calm = 1'b0;
	logic [63:0] key_pool [16];

	always #5 clk = ~clk;

	linear_probe_multivalue_table uut (.*);
	lpmt_checker chk (.*);

	always @(posedge clk) begin
		if (!calm && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		out_stall <= 1'b0;
	end

	task automatic send(lpmt_pkg::op_t o, logic [63:0] k, logic [15:0] m, logic [15:0] w,
		logic [3:0] mx);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		position_key <= k;
		move_code <= m;
		move_weight <= w;
		list_limit <= mx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [63:0] k;
		int r;
		for (int i = 0; i < 16; i++)
			key_pool[i] = {$urandom(), $urandom()};
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'd1024;
		key_pool[3] = 64'd2048;
		key_pool[4] = 64'd1023;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(lpmt_pkg::OP_SIZE, 0, 0, 0, 0);
		send(lpmt_pkg::OP_LIST, 0, 0, 0, 8);
		send(lpmt_pkg::OP_BEST, 0, 0, 0, 0);
		send(lpmt_pkg::OP_REMOVE, 0, 0, 0, 0);
		send(lpmt_pkg::OP_INSERT, 64'd0, 16'h0000, 16'hFFFF, 0);
		send(lpmt_pkg::OP_INSERT, 64'd1024, 16'hFFFF, 16'h0000, 0);
		send(lpmt_pkg::OP_INSERT, 64'd2048, 16'h1234, 16'h0001, 0);
		for (int j = 1; j <= 8; j++)
			send(lpmt_pkg::OP_INSERT, '1, 16'(j), (j == 3 || j == 6) ? 16'hFFFF : 16'(j), 0);
		send(lpmt_pkg::OP_INSERT, '1, 16'd99, 16'd1, 0);
		send(lpmt_pkg::OP_INSERT, 64'd0, 16'h0000, 16'd5, 0);
		send(lpmt_pkg::OP_LIST, '1, 0, 0, 15);
		send(lpmt_pkg::OP_LIST, '1, 0, 0, 0);
		send(lpmt_pkg::OP_LIST, '1, 0, 0, 3);
		send(lpmt_pkg::OP_BEST, '1, 0, 0, 0);
		send(lpmt_pkg::OP_REMOVE, 64'd1024, 0, 0, 0);
		send(lpmt_pkg::OP_LIST, 64'd2048, 0, 0, 8);
		send(lpmt_pkg::op_t'(3'd6), '1, '1, '1, '1);
		send(lpmt_pkg::op_t'(3'd7), 0, 0, 0, 0);
		send(lpmt_pkg::OP_CLEAR, 0, 0, 0, 0);
		send(lpmt_pkg::OP_SIZE, 0, 0, 0, 0);
		idle_until_drained();
		repeat (1100) @(posedge clk);
		for (int i = 0; i < 440; i++) begin
			if (i == 220) idle_until_drained();
			if (i == 380) calm = 1'b1;
			k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
				: key_pool[$urandom_range(0, 15)];
			r = $urandom_range(0, 99);
			if (r < 45)
				send(lpmt_pkg::OP_INSERT, k, 16'($urandom_range(0, 11)) ^ {16{r[0]}},
					16'($urandom()), 0);
			else if (r < 65) send(lpmt_pkg::OP_LIST, k, '1, '1, 4'($urandom_range(0, 15)));
			else if (r < 80) send(lpmt_pkg::OP_BEST, k, 0, 0, 0);
			else if (r < 92) send(lpmt_pkg::OP_REMOVE, k, 0, 0, 0);
			else if (r < 94) begin
				send(lpmt_pkg::OP_CLEAR, k, 0, 0, 0);
			end else send(lpmt_pkg::op_t'(3'($urandom_range(5, 7))), k, '1, 0,
				4'($urandom()));
		end
		idle_until_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
